>>> rtl/psb_pkg.sv
// Package for the pixel saturation boost core.
// Holds the shared widths, the divider geometry and the payload type carried alongside dividers.
// It depends on nothing.
package psb_pkg;

	localparam int CH_W       = 8;
	localparam int SUM_W      = 9;
	localparam int DEN_W      = 17;
	localparam int BITS_STG   = 4;
	localparam int NUM_BITS   = 33;
	localparam int DIV_STG    = (NUM_BITS + BITS_STG - 1) / BITS_STG;
	localparam int NUM_W      = DIV_STG * BITS_STG;
	localparam int SAT_W      = 17;
	localparam int FACTOR_W   = 24;
	localparam int DIFF_W     = 10;
	localparam int PROD_W     = DIFF_W + FACTOR_W + 1;
	localparam int ACC_W      = PROD_W + 1;
	localparam int FRAC_SH    = 17;
	localparam int LATENCY    = 2 * DIV_STG + 5;

	localparam logic [SAT_W-1:0] Q16_ONE = SAT_W'(65536);
	localparam logic [SUM_W-1:0] SUM_FULL = SUM_W'(510);
	localparam logic [CH_W-1:0] CH_MAX = 8'hff;

	typedef struct packed {
		logic [CH_W-1:0]  red;
		logic [CH_W-1:0]  green;
		logic [CH_W-1:0]  blue;
		logic [CH_W-1:0]  opacity;
		logic [SUM_W-1:0] sum;
		logic             zero_div;
	} side_t;

endpackage

>>> rtl/psb_div_pipe.sv
// Pipelined restoring divider, a fixed number of quotient bits per stage.
// Carries a psb_pkg::side_t word alongside each division.
// Depends on psb_pkg.
module psb_div_pipe (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [psb_pkg::NUM_W-1:0]  numer,
	input  logic [psb_pkg::DEN_W-1:0]  denom,
	input  psb_pkg::side_t             in_side,
	output logic                       out_valid,
	output logic [psb_pkg::NUM_W-1:0]  quot,
	output psb_pkg::side_t             out_side
);

	logic                      vld_s  [psb_pkg::DIV_STG];
	logic [psb_pkg::NUM_W-1:0] num_s  [psb_pkg::DIV_STG];
	logic [psb_pkg::NUM_W-1:0] quo_s  [psb_pkg::DIV_STG];
	logic [psb_pkg::DEN_W-1:0] rem_s  [psb_pkg::DIV_STG];
	logic [psb_pkg::DEN_W-1:0] den_s  [psb_pkg::DIV_STG];
	psb_pkg::side_t            side_s [psb_pkg::DIV_STG];

	logic                      vld_i  [psb_pkg::DIV_STG];
	logic [psb_pkg::NUM_W-1:0] num_i  [psb_pkg::DIV_STG];
	logic [psb_pkg::NUM_W-1:0] quo_i  [psb_pkg::DIV_STG];
	logic [psb_pkg::DEN_W-1:0] rem_i  [psb_pkg::DIV_STG];
	logic [psb_pkg::DEN_W-1:0] den_i  [psb_pkg::DIV_STG];
	psb_pkg::side_t            side_i [psb_pkg::DIV_STG];

	assign vld_i[0]  = in_valid;
	assign num_i[0]  = numer;
	assign quo_i[0]  = '0;
	assign rem_i[0]  = '0;
	assign den_i[0]  = denom;
	assign side_i[0] = in_side;

	for (genvar k = 0; k < psb_pkg::DIV_STG; k++) begin : g_stg
		logic [psb_pkg::NUM_W-1:0] num_n;
		logic [psb_pkg::NUM_W-1:0] quo_n;
		logic [psb_pkg::DEN_W-1:0] rem_n;

		if (k > 0) begin : g_link
			assign vld_i[k]  = vld_s[k-1];
			assign num_i[k]  = num_s[k-1];
			assign quo_i[k]  = quo_s[k-1];
			assign rem_i[k]  = rem_s[k-1];
			assign den_i[k]  = den_s[k-1];
			assign side_i[k] = side_s[k-1];
		end

		always_comb begin
			logic [psb_pkg::DEN_W:0] trial;
			num_n = num_i[k];
			quo_n = quo_i[k];
			rem_n = rem_i[k];
			for (int j = 0; j < psb_pkg::BITS_STG; j++) begin
				trial = {rem_n, num_n[psb_pkg::NUM_W-1]};
				num_n = {num_n[psb_pkg::NUM_W-2:0], 1'b0};
				if (trial >= {1'b0, den_i[k]}) begin
					trial = trial - {1'b0, den_i[k]};
					quo_n = {quo_n[psb_pkg::NUM_W-2:0], 1'b1};
				end else begin
					quo_n = {quo_n[psb_pkg::NUM_W-2:0], 1'b0};
				end
				rem_n = trial[psb_pkg::DEN_W-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_i[k];
			end
		end

		always_ff @(posedge clk) begin
			num_s[k]  <= num_n;
			quo_s[k]  <= quo_n;
			rem_s[k]  <= rem_n;
			den_s[k]  <= den_i[k];
			side_s[k] <= side_i[k];
		end
	end

	assign out_valid = vld_s[psb_pkg::DIV_STG-1];
	assign quot      = quo_s[psb_pkg::DIV_STG-1];
	assign out_side  = side_s[psb_pkg::DIV_STG-1];

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && den_s[psb_pkg::DIV_STG-1] != '0) |->
		(rem_s[psb_pkg::DIV_STG-1] < den_s[psb_pkg::DIV_STG-1]))
		else $error("divider remainder not below divisor");

	a_valid_travels: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> ##(psb_pkg::DIV_STG) out_valid)
		else $error("divider lost a word");

endmodule

>>> rtl/psb_lane.sv
// One colour channel of the output mix: scaled push away from lightness, then clamp.
// Two register stages: product, then sum and clamp.
// Depends on psb_pkg.
module psb_lane (
	input  logic                          clk,
	input  logic [psb_pkg::CH_W-1:0]      chan,
	input  logic [psb_pkg::SUM_W-1:0]     sum,
	input  logic [psb_pkg::FACTOR_W-1:0]  factor,
	output logic [psb_pkg::CH_W-1:0]      result
);

	logic signed [psb_pkg::DIFF_W-1:0] diff;
	logic signed [psb_pkg::PROD_W-1:0] prod_s4;
	logic [psb_pkg::CH_W-1:0]          chan_s4;
	logic signed [psb_pkg::ACC_W-1:0]  acc;
	logic [psb_pkg::ACC_W-1:0]         shifted;

	assign diff = $signed({1'b0, chan, 1'b0}) - $signed({1'b0, sum});

	always_ff @(posedge clk) begin
		prod_s4 <= psb_pkg::PROD_W'(diff) * psb_pkg::PROD_W'($signed({1'b0, factor}));
		chan_s4 <= chan;
	end

	assign acc = $signed({{(psb_pkg::ACC_W-psb_pkg::CH_W-psb_pkg::FRAC_SH){1'b0}},
		chan_s4, {psb_pkg::FRAC_SH{1'b0}}}) + psb_pkg::ACC_W'(prod_s4);
	assign shifted = psb_pkg::ACC_W'(acc >>> psb_pkg::FRAC_SH);

	always_ff @(posedge clk) begin
		if (acc <= 0) begin
			result <= '0;
		end else if (shifted > psb_pkg::ACC_W'(psb_pkg::CH_MAX)) begin
			result <= psb_pkg::CH_MAX;
		end else begin
			result <= shifted[psb_pkg::CH_W-1:0];
		end
	end

endmodule

>>> rtl/pixel_saturation_boost_core.sv
// Top level of the pixel saturation boost core.
// Depends on psb_pkg, psb_div_pipe and psb_lane.
//
// channel   handshake               payload
// pixel in  start / busy            in_red in_green in_blue in_opacity
// pixel out done (one-cycle strobe) out_red out_green out_blue out_opacity
// config    cfg_valid / cfg_ready   boost_amount
//
// One pixel word is accepted every cycle; busy never rises.
// A word passes the input, floor, factor and lane registers and the two 9-stage dividers.
// Reset clears the valid bits and the boost register; the config channel is always ready.
// Results cannot be held off and are shown for exactly one cycle.
module pixel_saturation_boost_core (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [psb_pkg::CH_W-1:0] in_red,
	input  logic [psb_pkg::CH_W-1:0] in_green,
	input  logic [psb_pkg::CH_W-1:0] in_blue,
	input  logic [psb_pkg::CH_W-1:0] in_opacity,
	output logic                     done,
	output logic [psb_pkg::CH_W-1:0] out_red,
	output logic [psb_pkg::CH_W-1:0] out_green,
	output logic [psb_pkg::CH_W-1:0] out_blue,
	output logic [psb_pkg::CH_W-1:0] out_opacity,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [psb_pkg::CH_W-1:0] boost_amount
);

	logic [psb_pkg::CH_W-1:0]     boost_q;
	logic                         vld_s1;
	psb_pkg::side_t               side_s1;
	logic [psb_pkg::CH_W-1:0]     mx;
	logic [psb_pkg::CH_W-1:0]     mn;
	logic [psb_pkg::SUM_W-1:0]    sum;
	logic [psb_pkg::SUM_W-1:0]    rest;
	logic [psb_pkg::CH_W-1:0]     spread;
	logic [psb_pkg::SUM_W-1:0]    div_in;
	psb_pkg::side_t               side_d1;

	logic                         vld_d1;
	logic [psb_pkg::NUM_W-1:0]    quo_d1;
	psb_pkg::side_t               side_o1;
	logic [psb_pkg::SAT_W-1:0]    sat;
	logic [psb_pkg::SAT_W-1:0]    floor_q;
	logic                         vld_s2;
	logic [psb_pkg::SAT_W-1:0]    a_s2;
	psb_pkg::side_t               side_s2;

	logic                         vld_d2;
	logic [psb_pkg::NUM_W-1:0]    quo_d2;
	psb_pkg::side_t               side_o2;
	logic                         vld_s3;
	logic [psb_pkg::FACTOR_W-1:0] factor_s3;
	psb_pkg::side_t               side_s3;
	logic                         vld_s4;
	logic [psb_pkg::CH_W-1:0]     op_s4;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boost_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			boost_q <= boost_amount;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_d1;
			vld_s3 <= vld_d2;
			vld_s4 <= vld_s3;
			done   <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		side_s1.red      <= in_red;
		side_s1.green    <= in_green;
		side_s1.blue     <= in_blue;
		side_s1.opacity  <= in_opacity;
		side_s1.sum      <= '0;
		side_s1.zero_div <= 1'b0;
	end

	always_comb begin
		mx = side_s1.red;
		mn = side_s1.red;
		if (side_s1.green > mx) mx = side_s1.green;
		if (side_s1.blue > mx) mx = side_s1.blue;
		if (side_s1.green < mn) mn = side_s1.green;
		if (side_s1.blue < mn) mn = side_s1.blue;
		sum    = {1'b0, mx} + {1'b0, mn};
		rest   = psb_pkg::SUM_FULL - sum;
		spread = mx - mn;
		div_in = (sum < rest) ? sum : rest;
		side_d1          = side_s1;
		side_d1.sum      = sum;
		side_d1.zero_div = (div_in == '0);
	end

	psb_div_pipe u_sat_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s1),
		.numer     (psb_pkg::NUM_W'({spread, 16'h0000})),
		.denom     (psb_pkg::DEN_W'(div_in)),
		.in_side   (side_d1),
		.out_valid (vld_d1),
		.quot      (quo_d1),
		.out_side  (side_o1)
	);

	assign sat     = side_o1.zero_div ? '0 : quo_d1[psb_pkg::SAT_W-1:0];
	assign floor_q = psb_pkg::Q16_ONE - {1'b0, boost_q, 8'h00};

	always_ff @(posedge clk) begin
		a_s2    <= (sat > floor_q) ? sat : floor_q;
		side_s2 <= side_o1;
	end

	psb_div_pipe u_factor_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s2),
		.numer     (psb_pkg::NUM_W'(64'h1_0000_0000)),
		.denom     (a_s2),
		.in_side   (side_s2),
		.out_valid (vld_d2),
		.quot      (quo_d2),
		.out_side  (side_o2)
	);

	always_ff @(posedge clk) begin
		factor_s3 <= psb_pkg::FACTOR_W'(quo_d2[psb_pkg::FACTOR_W:0] - 25'd65536);
		side_s3   <= side_o2;
		op_s4     <= side_s3.opacity;
		out_opacity <= op_s4;
	end

	psb_lane u_red (
		.clk    (clk),
		.chan   (side_s3.red),
		.sum    (side_s3.sum),
		.factor (factor_s3),
		.result (out_red)
	);

	psb_lane u_green (
		.clk    (clk),
		.chan   (side_s3.green),
		.sum    (side_s3.sum),
		.factor (factor_s3),
		.result (out_green)
	);

	psb_lane u_blue (
		.clk    (clk),
		.chan   (side_s3.blue),
		.sum    (side_s3.sum),
		.factor (factor_s3),
		.result (out_blue)
	);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(psb_pkg::LATENCY) done)
		else $error("pixel word did not arrive after the pipeline latency");

	a_floor_min: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> (a_s2 >= psb_pkg::SAT_W'(256) && a_s2 <= psb_pkg::Q16_ONE))
		else $error("saturation floor out of range");

	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_d1 |-> (sat <= psb_pkg::Q16_ONE))
		else $error("saturation above one");

endmodule
